// ===== hdl/ilbp_window_code_unit_defines.svh =====
// assertion macros for the ilbp window code unit
// used by the top level and the code pipeline; expects clk and rst_n in scope
`ifndef ILBP_WINDOW_CODE_UNIT_DEFINES_SVH
`define ILBP_WINDOW_CODE_UNIT_DEFINES_SVH

// same-cycle implication
`define ILBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ILBP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ilbp_pkg.sv =====
// shared constants, types and helpers for the ilbp window code unit
// no dependencies
`default_nettype none

package ilbp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int CODE_W    = 9;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int WIN_N     = 9;
    localparam int MIN_SIZE  = 3;

    // floor(sum / 9) as (sum * 3641) >> 15, exact for sum below 32768
    localparam int SUM_W      = 12;
    localparam int MEAN_MUL   = 3641;
    localparam int MEAN_MUL_W = 12;
    localparam int MEAN_SHIFT = 15;
    localparam int PROD_W     = SUM_W + MEAN_MUL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [CODE_W-1:0] code_t;
    typedef pix_t [WIN_N-1:0]  win_t;

    typedef struct packed {
        row_t row;
        col_t col;
        logic frame_end;
    } pos_t;

    typedef struct packed {
        logic rd_en;
        col_t rd_addr;
        logic wr_en;
        col_t wr_addr;
    } lb_ctrl_t;

    // last column index for a written width, clamped to the legal range
    function automatic col_t last_col(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] dec;
        col_t             res;
        dec = v - CFG_W'(1);
        if (v < CFG_W'(MIN_SIZE))
            res = col_t'(MIN_SIZE - 1);
        else if (v > CFG_W'(MAX_WIDTH))
            res = col_t'(MAX_WIDTH - 1);
        else
            res = dec[COL_W-1:0];
        return res;
    endfunction

    // last row index for a written height, clamped to the legal range
    function automatic row_t last_row(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] dec;
        row_t             res;
        dec = v - CFG_W'(1);
        if (v < CFG_W'(MIN_SIZE))
            res = row_t'(MIN_SIZE - 1);
        else if (v > CFG_W'(MAX_HEIGHT))
            res = row_t'(MAX_HEIGHT - 1);
        else
            res = dec[ROW_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ilbp_pixel_if.sv =====
// pixel input channel: valid/ready handshake with one grey pixel per item
// depends on ilbp_pkg
`default_nettype none

interface ilbp_pixel_if;
    import ilbp_pkg::*;

    logic valid;
    logic ready;
    pix_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== hdl/ilbp_code_if.sv =====
// code output channel: valid/ready handshake with pattern code and centre position
// depends on ilbp_pkg
`default_nettype none

interface ilbp_code_if;
    import ilbp_pkg::*;

    logic  valid;
    logic  ready;
    code_t code;
    row_t  center_row;
    col_t  center_col;
    logic  frame_end;

    modport source (output valid, output code, output center_row, output center_col,
                    output frame_end, input ready);
    modport sink   (input valid, input code, input center_row, input center_col,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/ilbp_line_buf.sv =====
// two line stores holding the two previous image rows, registered read
// depends on ilbp_pkg
`default_nettype none

module ilbp_line_buf (
    input  wire                      clk,
    input  wire ilbp_pkg::lb_ctrl_t  ctrl,
    input  wire ilbp_pkg::pix_t      wr_upper,
    input  wire ilbp_pkg::pix_t      wr_middle,
    output ilbp_pkg::pix_t           upper_q,
    output ilbp_pkg::pix_t           middle_q
);
    import ilbp_pkg::*;

    pix_t upper_mem  [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            upper_q  <= upper_mem[ctrl.rd_addr];
            middle_q <= middle_mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            upper_mem[ctrl.wr_addr]  <= wr_upper;
            middle_mem[ctrl.wr_addr] <= wr_middle;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ilbp_code_pipe.sv =====
// window sum, mean and threshold stages ending in the output register
// depends on ilbp_pkg, ilbp_code_if and the assertion macro header
`default_nettype none
`include "ilbp_window_code_unit_defines.svh"

module ilbp_code_pipe (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    input  wire ilbp_pkg::win_t      in_win,
    input  wire ilbp_pkg::pos_t      in_pos,
    output logic                     in_ready,
    ilbp_code_if.source              out
);
    import ilbp_pkg::*;

    logic  s_valid_reg;
    sum_t  s_sum_reg;
    win_t  s_win_reg;
    pos_t  s_pos_reg;

    logic  m_valid_reg;
    pix_t  m_mean_reg;
    win_t  m_win_reg;
    pos_t  m_pos_reg;

    logic  o_valid_reg;
    code_t o_code_reg;
    pos_t  o_pos_reg;

    logic  o_free;
    logic  m_free;
    logic  s_free;

    sum_t  sum_next;
    logic [PROD_W-1:0] prod;
    code_t code_next;

    assign o_free   = !o_valid_reg || out.ready;
    assign m_free   = !m_valid_reg || o_free;
    assign s_free   = !s_valid_reg || m_free;
    assign in_ready = s_free;

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < WIN_N; k++)
            sum_next = sum_next + sum_t'(in_win[k]);
    end

    assign prod = PROD_W'(s_sum_reg) * PROD_W'(MEAN_MUL);

    always_comb
    begin
        code_next = '0;
        for (int k = 0; k < WIN_N; k++)
            code_next[CODE_W-1-k] = (m_win_reg[k] > m_mean_reg);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_free)
                s_valid_reg <= in_valid;
            if (m_free)
                m_valid_reg <= s_valid_reg;
            if (o_free)
                o_valid_reg <= m_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_free && in_valid)
        begin
            s_sum_reg <= sum_next;
            s_win_reg <= in_win;
            s_pos_reg <= in_pos;
        end
        if (m_free && s_valid_reg)
        begin
            m_mean_reg <= prod[MEAN_SHIFT +: PIX_W];
            m_win_reg  <= s_win_reg;
            m_pos_reg  <= s_pos_reg;
        end
        if (o_free && m_valid_reg)
        begin
            o_code_reg <= code_next;
            o_pos_reg  <= m_pos_reg;
        end
    end

    assign out.valid      = o_valid_reg;
    assign out.code       = o_code_reg;
    assign out.center_row = o_pos_reg.row;
    assign out.center_col = o_pos_reg.col;
    assign out.frame_end  = o_pos_reg.frame_end;

    `ILBP_ASSERT_NXT(mean_hold_chk, m_valid_reg && !o_free,
        m_valid_reg && $stable(m_mean_reg) && $stable(m_pos_reg), "mean stage lost on stall")
    `ILBP_ASSERT_NXT(sum_hold_chk, s_valid_reg && !m_free,
        s_valid_reg && $stable(s_sum_reg), "sum stage lost on stall")
    `ILBP_ASSERT_NOW(ready_chk, s_valid_reg && m_valid_reg && o_valid_reg && !out.ready,
        !in_ready, "pipeline full but input ready")

endmodule

`default_nettype wire

// ===== hdl/ilbp_window_code_unit.sv =====
// ilbp window code unit: top level with counters, 3x3 window and line stores
// depends on ilbp_pkg, ilbp_pixel_if, ilbp_code_if, ilbp_line_buf, ilbp_code_pipe
//
// pix_in carries one grey pixel per item in raster order; code_out carries one
// item per interior pixel: 9-bit pattern (bit 8 top-left .. bit 0 bottom-right,
// set where the pixel is above the truncated 3x3 mean), centre row and column,
// and frame_end on the last code of a frame. pixels in the first two rows or
// first two columns give no code.
// cfg_write_en/cfg_index/cfg_data set image_width (index 0) and image_height
// (index 1), clamped to 3..1024; any such write restarts the frame at row 0.
// other indexes are ignored. write only while no item is in flight.
// a pixel passes the input stage, sum stage, mean stage and output register before
// its code is valid.
// throughput: one pixel per cycle while code_out does not stall, limited by the single line
// store port pair read at accept and written when the item leaves the input stage.
// reset: size 1024x1024, position row 0 col 0, pipeline empty; the line stores
// are not cleared, the first two rows of a frame fill them.
// when code_out stalls, the stages fill up and pix_in.ready drops only once
// no stage has room.
`default_nettype none
`include "ilbp_window_code_unit_defines.svh"

module ilbp_window_code_unit (
    input  wire                            clk,
    input  wire                            rst_n,
    ilbp_pixel_if.sink                     pix_in,
    ilbp_code_if.source                    code_out,
    input  wire                            cfg_write_en,
    input  wire [ilbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [ilbp_pkg::CFG_W-1:0]      cfg_data
);
    import ilbp_pkg::*;

    col_t     wcol_last_reg;
    row_t     hrow_last_reg;
    col_t     col_count_reg;
    col_t     col_count_next;
    row_t     row_count_reg;
    row_t     row_count_next;

    logic     a_valid_reg;
    pix_t     a_pix_reg;
    col_t     a_col_reg;
    logic     a_interior_reg;
    pos_t     a_pos_reg;

    win_t     win_reg;
    win_t     win_next;

    logic     accept;
    logic     a_adv;
    logic     pipe_ready;
    logic     cfg_hit;
    lb_ctrl_t lb_ctrl;
    pix_t     upper_q;
    pix_t     middle_q;

    assign accept       = pix_in.valid && pix_in.ready;
    assign a_adv        = a_valid_reg && (!a_interior_reg || pipe_ready);
    assign pix_in.ready = !a_valid_reg || a_adv;
    assign cfg_hit      = cfg_write_en && (cfg_index == REG_IMAGE_WIDTH
                                           || cfg_index == REG_IMAGE_HEIGHT);

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcol_last_reg <= col_t'(MAX_WIDTH - 1);
            hrow_last_reg <= row_t'(MAX_HEIGHT - 1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  wcol_last_reg <= last_col(cfg_data);
                REG_IMAGE_HEIGHT: hrow_last_reg <= last_row(cfg_data);
                default:          ;
            endcase
        end
    end

    // raster position
    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (cfg_hit)
        begin
            col_count_next = '0;
            row_count_next = '0;
        end
        else if (accept)
        begin
            if (col_count_reg == wcol_last_reg)
            begin
                col_count_next = '0;
                if (row_count_reg == hrow_last_reg)
                    row_count_next = '0;
                else
                    row_count_next = row_count_reg + row_t'(1);
            end
            else
                col_count_next = col_count_reg + col_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (pix_in.ready)
            a_valid_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg           <= pix_in.pixel;
            a_col_reg           <= col_count_reg;
            a_interior_reg      <= (row_count_reg >= row_t'(2)) && (col_count_reg >= col_t'(2));
            a_pos_reg.row       <= row_count_reg - row_t'(1);
            a_pos_reg.col       <= col_count_reg - col_t'(1);
            a_pos_reg.frame_end <= (row_count_reg == hrow_last_reg)
                                   && (col_count_reg == wcol_last_reg);
        end
    end

    // line stores: read on accept, write back when the item leaves the input stage
    always_comb
    begin
        lb_ctrl.rd_en   = accept;
        lb_ctrl.rd_addr = col_count_reg;
        lb_ctrl.wr_en   = a_adv;
        lb_ctrl.wr_addr = a_col_reg;
    end

    ilbp_line_buf u_line_buf (
        .clk       (clk),
        .ctrl      (lb_ctrl),
        .wr_upper  (middle_q),
        .wr_middle (a_pix_reg),
        .upper_q   (upper_q),
        .middle_q  (middle_q)
    );

    // window shifts one column left per pixel
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = upper_q;
        win_next[5] = middle_q;
        win_next[8] = a_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (a_adv)
            win_reg <= win_next;
    end

    ilbp_code_pipe u_code_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (a_valid_reg && a_interior_reg),
        .in_win   (win_next),
        .in_pos   (a_pos_reg),
        .in_ready (pipe_ready),
        .out      (code_out)
    );

    `ILBP_ASSERT_NOW(col_range_chk, 1'b1, col_count_reg <= wcol_last_reg,
        "column counter past row end")
    `ILBP_ASSERT_NOW(row_range_chk, 1'b1, row_count_reg <= hrow_last_reg,
        "row counter past frame end")
    `ILBP_ASSERT_NXT(col_wrap_chk, accept && col_count_reg == wcol_last_reg,
        col_count_reg == '0, "column did not wrap at row end")
    `ILBP_ASSERT_NXT(a_hold_chk, a_valid_reg && !a_adv,
        a_valid_reg && $stable(a_col_reg) && $stable(a_pix_reg), "input stage lost on stall")

endmodule

`default_nettype wire

// ===== tb/tb_ilbp_window_code_unit.sv =====
// self-checking testbench for the ilbp window code unit: directed frames, then random frames
// depends on ilbp_pkg, ilbp_pixel_if, ilbp_code_if and ilbp_window_code_unit
`timescale 1ns / 1ps

module tb_ilbp_window_code_unit;
    import ilbp_pkg::*;

    localparam int RANDOM_ITEMS   = 880;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PLAN_LEN       = 18;

    localparam logic [CFG_IDX_W-1:0] NO_REG      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic {STEP_CFG, STEP_PIX} step_kind_t;
    typedef enum logic [1:0] {PAT_NOISE, PAT_TEXTURE, PAT_FLAT} pattern_t;

    typedef struct packed {
        code_t code;
        row_t  row;
        col_t  col;
        logic  fend;
    } code_item_t;

    typedef struct packed {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        int                   reps;
        logic                 typed;
        code_item_t           want;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ilbp_pixel_if pix_if ();
    ilbp_code_if  code_if ();

    ilbp_window_code_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_in       (pix_if),
        .code_out     (code_if),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // raster predictor state
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_t             upper_row  [MAX_WIDTH];
    pix_t             middle_row [MAX_WIDTH];
    pix_t             window_px  [WIN_N];
    int               next_col;
    int               next_row;

    code_item_t pending_codes [$];
    code_item_t oldest;
    int         fail_count   = 0;
    int         stall_cycles = 0;
    int         tx_idle_pct  = 32;
    int         rx_idle_pct  = 88;

    // directed frames: width written first, then 3x3 frames and register corner cases
    plan_row_t plan [PLAN_LEN] = '{
        '{STEP_CFG, REG_IMAGE_WIDTH, 11'd0, 0, 1'b0, '0},
        '{STEP_PIX, NO_REG, 11'd0, 8, 1'b0, '0},
        '{STEP_PIX, NO_REG, 11'd255, 1, 1'b1, '{9'h001, 10'd1, 10'd1, 1'b0}},
        '{STEP_CFG, REG_IMAGE_HEIGHT, 11'd2, 0, 1'b0, '0},
        '{STEP_PIX, NO_REG, 11'd0, 8, 1'b0, '0},
        '{STEP_PIX, NO_REG, 11'd255, 1, 1'b1, '{9'h001, 10'd1, 10'd1, 1'b1}},
        '{STEP_PIX, NO_REG, 11'd255, 8, 1'b0, '0},
        '{STEP_PIX, NO_REG, 11'd0, 1, 1'b1, '{9'h1FE, 10'd1, 10'd1, 1'b1}},
        '{STEP_PIX, NO_REG, 11'd255, 9, 1'b1, '{9'h000, 10'd1, 10'd1, 1'b1}},
        '{STEP_PIX, NO_REG, 11'd200, 1, 1'b0, '0},
        '{STEP_PIX, NO_REG, 11'd0, 8, 1'b1, '{9'h100, 10'd1, 10'd1, 1'b1}},
        '{STEP_PIX, NO_REG, 11'd7, 4, 1'b0, '0},
        '{STEP_CFG, REG_SPARE_2, 11'd2047, 0, 1'b0, '0},
        '{STEP_CFG, REG_SPARE_3, 11'd1365, 0, 1'b0, '0},
        '{STEP_PIX, NO_REG, 11'd7, 5, 1'b1, '{9'h000, 10'd1, 10'd1, 1'b1}},
        '{STEP_PIX, NO_REG, 11'd9, 5, 1'b0, '0},
        '{STEP_CFG, REG_IMAGE_WIDTH, 11'd3, 0, 1'b0, '0},
        '{STEP_PIX, NO_REG, 11'd0, 9, 1'b1, '{9'h000, 10'd1, 10'd1, 1'b1}}
    };

    always #5 clk = ~clk;

    function automatic int eff_size(input logic [CFG_W-1:0] v, input int hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic void raster_reset();
        width_reg  = CFG_W'(MAX_WIDTH);
        height_reg = CFG_W'(MAX_HEIGHT);
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        for (int k = 0; k < WIN_N; k++)
            window_px[k] = '0;
        next_col = 0;
        next_row = 0;
    endfunction

    function automatic void raster_configure(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_W-1:0] val);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = val;
        else
            return;
        next_col = 0;
        next_row = 0;
    endfunction

    // shift one pixel into the window; returns 1 when an interior code is due
    function automatic bit raster_code(input pix_t px, output code_item_t res);
        int ew;
        int eh;
        int c;
        int r;
        int sum;
        int mean;
        bit hit;
        ew  = eff_size(width_reg, MAX_WIDTH);
        eh  = eff_size(height_reg, MAX_HEIGHT);
        c   = (next_col >= ew) ? 0 : next_col;
        r   = (next_row >= eh) ? 0 : next_row;
        res = '0;
        hit = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            window_px[k*3]   = window_px[k*3+1];
            window_px[k*3+1] = window_px[k*3+2];
        end
        window_px[2]  = upper_row[c];
        window_px[5]  = middle_row[c];
        window_px[8]  = px;
        upper_row[c]  = middle_row[c];
        middle_row[c] = px;
        if (r >= 2 && c >= 2)
        begin
            sum = 0;
            for (int k = 0; k < WIN_N; k++)
                sum += window_px[k];
            mean = sum / 9;
            for (int k = 0; k < WIN_N; k++)
                res.code[8-k] = (window_px[k] > mean);
            res.row  = row_t'(r - 1);
            res.col  = col_t'(c - 1);
            res.fend = (r == eh - 1) && (c == ew - 1);
            hit = 1'b1;
        end
        c++;
        if (c >= ew)
        begin
            c = 0;
            r++;
            if (r >= eh)
                r = 0;
        end
        next_col = c;
        next_row = r;
        return hit;
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int roll = $urandom_range(19);
        if (roll == 0)
            return CFG_W'($urandom_range(2));
        if (roll == 1)
            return CFG_W'($urandom_range(2047, 1025));
        return CFG_W'($urandom_range(10, 3));
    endfunction

    function automatic pix_t pick_pixel(input pattern_t style, input pix_t base);
        if (style == PAT_NOISE)
            return pix_t'($urandom_range(255));
        if (style == PAT_TEXTURE)
            return pix_t'(int'(base) + int'($urandom_range(6)) - 3);
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return base;
    endfunction

    task automatic send_pixel(input pix_t p, input bit typed, input code_item_t want);
        code_item_t predicted;
        bit         hit;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= p;
        do
            @(posedge clk);
        while (pix_if.ready !== 1'b1);
        hit = raster_code(p, predicted);
        if (typed)
            pending_codes.push_back(want);
        else if (hit)
            pending_codes.push_back(predicted);
    endtask

    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        raster_configure(idx, val);
    endtask

    // code channel: random back-pressure and in-order checking
    always @(posedge clk)
    begin
        if (!rst_n)
            code_if.ready <= 1'b0;
        else
        begin
            if (code_if.valid && code_if.ready)
            begin
                if (pending_codes.size() == 0)
                begin
                    $error("code item with none expected: code %0h row %0d col %0d",
                           code_if.code, code_if.center_row, code_if.center_col);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_codes.pop_front();
                    if (code_if.code !== oldest.code)
                    begin
                        $error("code: expected %0h, got %0h", oldest.code, code_if.code);
                        fail_count++;
                    end
                    if (code_if.center_row !== oldest.row)
                    begin
                        $error("center_row: expected %0d, got %0d", oldest.row,
                               code_if.center_row);
                        fail_count++;
                    end
                    if (code_if.center_col !== oldest.col)
                    begin
                        $error("center_col: expected %0d, got %0d", oldest.col,
                               code_if.center_col);
                        fail_count++;
                    end
                    if (code_if.frame_end !== oldest.fend)
                    begin
                        $error("frame_end: expected %0d, got %0d", oldest.fend,
                               code_if.frame_end);
                        fail_count++;
                    end
                end
            end
            code_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !(pix_if.valid && pix_if.ready) && !(code_if.valid && code_if.ready))
            stall_cycles <= stall_cycles + 1;
        else
            stall_cycles <= 0;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int               noise_items;
        int               count;
        int               ew;
        int               eh;
        int               sel;
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        pattern_t         style;
        pix_t             base;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pix_if.valid  = 1'b0;
        pix_if.pixel  = '0;
        code_if.ready = 1'b0;
        raster_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CFG)
            begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                for (int n = 0; n < plan[i].reps; n++)
                    send_pixel(pix_t'(plan[i].val), plan[i].typed && n == plan[i].reps - 1,
                               plan[i].want);
            end
        end

        noise_items = 0;
        while (noise_items < RANDOM_ITEMS)
        begin
            if (noise_items < RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 32;
                rx_idle_pct = 88;
            end
            else if (noise_items < 2 * RANDOM_ITEMS / 3)
            begin
                tx_idle_pct = 88;
                rx_idle_pct = 32;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wv  = pick_size();
            hv  = pick_size();
            sel = $urandom_range(3);
            wait_drained();
            if (sel == 3)
            begin
                write_reg(REG_IMAGE_HEIGHT, hv);
                write_reg(REG_IMAGE_WIDTH, wv);
            end
            else
            begin
                if (sel != 1)
                    write_reg(REG_IMAGE_WIDTH, wv);
                if (sel != 2)
                    write_reg(REG_IMAGE_HEIGHT, hv);
            end
            ew = eff_size(width_reg, MAX_WIDTH);
            eh = eff_size(height_reg, MAX_HEIGHT);
            if (ew * eh > 400)
                count = $urandom_range(120, 5);
            else
                count = $urandom_range(ew * eh + 2 * ew, 1);
            style = pattern_t'($urandom_range(2));
            base  = pix_t'($urandom);
            repeat (count) send_pixel(pick_pixel(style, base), 1'b0, '0);
            noise_items += count;
        end

        wait_drained();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ilbp_pkg.sv
hdl/ilbp_pixel_if.sv
hdl/ilbp_code_if.sv
hdl/ilbp_line_buf.sv
hdl/ilbp_code_pipe.sv
hdl/ilbp_window_code_unit.sv
tb/tb_ilbp_window_code_unit.sv
